// File: sv/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

    localparam int NUM_TIMERS_DEF = 16;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_REM_WIN = 2'd2,
        ACT_REM_ID  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_TIMEOUT = 2'd0,
        KIND_ADDED   = 2'd1,
        KIND_FULL    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [7:0]  window;
        logic [15:0] ident;
        logic [15:0] period;
        logic [15:0] count;
    } slot_t;

endpackage

// File: sv/periodic_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_timer_bank
// Bank of periodic timers kept as a linked active list and a free chain over
// a slot table held in two synchronous memories (slot data and links).
// ----------------------------------------------------------------------------
// add: after acceptance, ST_ADD loads the result into the output register once
// the output is free; the next word is accepted after that. tick and remove: the
// walk visits one slot per cycle through the slot memory read port, unless output backpressure stalls it.
// reset: lists empty, free chain in slot order; a fill count stands in for
// the initial free links, so there is no clearing pass after reset.
module periodic_timer_bank #(
    parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  window_id,
    input  logic [15:0] timer_id,
    input  logic [15:0] interval_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  window_id_out,
    output logic        last
);
    import ptb_pkg::*;

    localparam int AW = $clog2(NUM_TIMERS);
    localparam int LW = $clog2(NUM_TIMERS + 1);
    localparam logic [LW-1:0] NONE = LW'(NUM_TIMERS);

    // slot memories
    slot_t           data_mem [NUM_TIMERS];
    logic [LW-1:0]   link_mem [NUM_TIMERS];
    slot_t           data_rdata;
    logic [LW-1:0]   link_rdata;
    logic [LW-1:0]   rd_sel;
    logic [AW-1:0]   rd_addr;
    logic            data_we;
    logic [AW-1:0]   data_waddr;
    slot_t           data_wdata;
    logic            link_we;
    logic [AW-1:0]   link_waddr;
    logic [LW-1:0]   link_wdata;

    state_t          state_reg, state_next;
    logic [LW-1:0]   cur_reg, cur_next;
    logic [LW-1:0]   prev_reg, prev_next;
    logic [LW-1:0]   plink_reg, plink_next;
    logic            pdirty_reg, pdirty_next;
    logic [LW-1:0]   active_head_reg, active_head_next;
    logic [LW-1:0]   free_head_reg, free_head_next;
    logic [LW-1:0]   fill_reg, fill_next;
    action_t         act_reg, act_next;
    logic [7:0]      win_reg, win_next;
    logic [15:0]     id_reg, id_next;
    logic [15:0]     per_reg, per_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [7:0]      pend_win_reg, pend_win_next;
    logic            out_valid_reg, out_valid_next;
    kind_t           out_kind_reg, out_kind_next;
    logic [7:0]      out_win_reg, out_win_next;
    logic            out_last_reg, out_last_next;

    logic            out_free;
    logic [16:0]     count_inc;
    logic            fire;
    logic            hit;

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        data_rdata <= data_mem[rd_addr];
        link_rdata <= link_mem[rd_addr];
    end

    // link code none is mapped to address zero, so it never reads beyond the table
    assign rd_addr = (rd_sel >= NONE) ? '0 : rd_sel[AW-1:0];

    assign out_free  = !out_valid_reg || out_ready;
    assign count_inc = {1'b0, data_rdata.count} + 17'd1;
    assign fire      = count_inc >= {1'b0, data_rdata.period};
    assign hit       = (data_rdata.window == win_reg) &&
                       ((act_reg != ACT_REM_ID) || (data_rdata.ident == id_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_reg         <= NONE;
            prev_reg        <= NONE;
            pdirty_reg      <= 1'b0;
            active_head_reg <= NONE;
            free_head_reg   <= '0;
            fill_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            prev_reg        <= prev_next;
            pdirty_reg      <= pdirty_next;
            active_head_reg <= active_head_next;
            free_head_reg   <= free_head_next;
            fill_reg        <= fill_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plink_reg    <= plink_next;
        act_reg      <= act_next;
        win_reg      <= win_next;
        id_reg       <= id_next;
        per_reg      <= per_next;
        pend_win_reg <= pend_win_next;
        out_kind_reg <= out_kind_next;
        out_win_reg  <= out_win_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        plink_next       = plink_reg;
        pdirty_next      = pdirty_reg;
        active_head_next = active_head_reg;
        free_head_next   = free_head_reg;
        fill_next        = fill_reg;
        act_next         = act_reg;
        win_next         = win_reg;
        id_next          = id_reg;
        per_next         = per_reg;
        pend_valid_next  = pend_valid_reg;
        pend_win_next    = pend_win_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_kind_next    = out_kind_reg;
        out_win_next     = out_win_reg;
        out_last_next    = out_last_reg;
        in_ready         = 1'b0;
        rd_sel           = cur_reg;
        data_we          = 1'b0;
        data_waddr       = cur_reg[AW-1:0];
        data_wdata       = data_rdata;
        link_we          = 1'b0;
        link_waddr       = cur_reg[AW-1:0];
        link_wdata       = free_head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    act_next = action_t'(action);
                    win_next = window_id;
                    id_next  = timer_id;
                    per_next = interval_ticks;
                    if (action_t'(action) == ACT_ADD)
                    begin
                        rd_sel     = free_head_reg;
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        rd_sel      = active_head_reg;
                        cur_next    = active_head_reg;
                        prev_next   = NONE;
                        pdirty_next = 1'b0;
                        state_next  = ST_WALK;
                    end
                end
            end

            ST_ADD:
            begin
                rd_sel = free_head_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_win_next   = win_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                    if (free_head_reg == NONE)
                    begin
                        out_kind_next = KIND_FULL;
                    end
                    else
                    begin
                        out_kind_next     = KIND_ADDED;
                        data_we           = 1'b1;
                        data_waddr        = free_head_reg[AW-1:0];
                        data_wdata.window = win_reg;
                        data_wdata.ident  = id_reg;
                        data_wdata.period = per_reg;
                        data_wdata.count  = '0;
                        link_we           = 1'b1;
                        link_waddr        = free_head_reg[AW-1:0];
                        link_wdata        = active_head_reg;
                        active_head_next  = free_head_reg;
                        // a slot never handed out yet links to the next fresh slot
                        if (free_head_reg == fill_reg)
                        begin
                            free_head_next = free_head_reg + LW'(1);
                            fill_next      = fill_reg + LW'(1);
                        end
                        else
                        begin
                            free_head_next = link_rdata;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                if (cur_reg == NONE)
                begin
                    state_next = ST_FLUSH;
                end
                else if (act_reg == ACT_TICK)
                begin
                    // a timeout is held back until the next one fires or the walk ends, so the final one can carry last
                    if (!(fire && pend_valid_reg && !out_free))
                    begin
                        data_we          = 1'b1;
                        data_wdata.count = fire ? 16'd0 : count_inc[15:0];
                        if (fire)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_TIMEOUT;
                                out_win_next   = pend_win_reg;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_win_next   = data_rdata.window;
                        end
                        cur_next = link_rdata;
                        rd_sel   = link_rdata;
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        link_we        = 1'b1;
                        link_wdata     = free_head_reg;
                        free_head_next = cur_reg;
                        if (prev_reg == NONE)
                        begin
                            active_head_next = link_rdata;
                        end
                        else
                        begin
                            // unlink from prev later, the write port is busy now
                            plink_next  = link_rdata;
                            pdirty_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (pdirty_reg)
                        begin
                            link_we     = 1'b1;
                            link_waddr  = prev_reg[AW-1:0];
                            link_wdata  = plink_reg;
                            pdirty_next = 1'b0;
                        end
                        prev_next = cur_reg;
                    end
                    cur_next = link_rdata;
                    rd_sel   = link_rdata;
                end
            end

            ST_FLUSH:
            begin
                if (pdirty_reg)
                begin
                    link_we     = 1'b1;
                    link_waddr  = prev_reg[AW-1:0];
                    link_wdata  = plink_reg;
                    pdirty_next = 1'b0;
                end
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_TIMEOUT;
                        out_win_next    = pend_win_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign window_id_out = out_win_reg;
    assign last          = out_last_reg;

endmodule
